### design/plane_equation_setup_core_defines.svh
// ----------------------------------------------------------------------------
// Plane equation setup: assertion macros
// Concurrent assertion helpers shared by the plane equation setup RTL.
// ----------------------------------------------------------------------------
`ifndef PLANE_EQUATION_SETUP_CORE_DEFINES_SVH
`define PLANE_EQUATION_SETUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked while out of reset
`define PES_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("plane setup check failed");

// next-cycle implication, checked while out of reset
`define PES_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("plane setup check failed");

`else

`define PES_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define PES_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### design/pes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Plane equation setup package
// Widths, constants and the per-item side information carried down the pipe.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int COORD_W    = 32;
    localparam int EDGE_W     = 33;
    localparam int PROD_W     = 66;
    localparam int RAW_W      = 67;
    localparam int MAG_W      = 66;
    localparam int BITS_W     = 7;
    localparam int HALF_W     = 24;
    localparam int SQ_W       = 96;
    localparam int LEN2_W     = 98;
    localparam int THR_W      = 63;
    localparam int NORM_W     = 31;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int NUM_W      = 62;

    localparam logic [THR_W-1:0]  THRESH_RESET = 63'd4295;
    localparam logic [NORM_W-1:0] ONE_Q30      = 31'h4000_0000;
    localparam logic [BITS_W-1:0] BIG_BITS     = 7'd48;

    typedef struct packed {
        logic                      pn;
        logic                      up;
        logic                      deg;
        logic [2:0]                neg;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } side_t;

endpackage
`default_nettype wire

### design/plane_equation_setup_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Plane equation setup core
// Plane a*x+b*y+c*z+d=0 from three points or from a point and a normal.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  input   | s_valid s_ready s_req_type .. s_third_z | in
//  result  | m_valid m_ready m_plane_ok m_coef_a..d | out
//  config  | cfg_wr_en cfg_wr_data                  | in
//
// One item enters per cycle while no result waits on m_ready.
// The pipe holds a 32-step square root and 31-step divider lanes.
// Reset (aresetn low, synchronous) clears the valid bits and reloads the
// default threshold.
// The whole pipe holds while a result waits on m_ready; nothing is dropped.
`include "plane_equation_setup_core_defines.svh"

module plane_equation_setup_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pes_pkg::THR_W-1:0]          cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_req_type,
    input  wire logic                               s_force_up,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_base_x,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_base_y,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_base_z,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_second_x,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_second_y,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_second_z,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_third_x,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_third_y,
    input  wire logic signed [pes_pkg::COORD_W-1:0] s_third_z,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_plane_ok,
    output logic signed [pes_pkg::COORD_W-1:0]      m_coef_a,
    output logic signed [pes_pkg::COORD_W-1:0]      m_coef_b,
    output logic signed [pes_pkg::COORD_W-1:0]      m_coef_c,
    output logic signed [pes_pkg::COORD_W-1:0]      m_coef_d
);
    import pes_pkg::*;

    logic en;
    logic [THR_W-1:0] thr_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // ---------------- A: edge vectors ----------------
    logic                     a_valid_reg;
    side_t                    a_side_reg, a_side_next;
    logic signed [EDGE_W-1:0] a_u_reg [3];
    logic signed [EDGE_W-1:0] a_v_reg [3];
    logic signed [EDGE_W-1:0] a_u_next [3];
    logic signed [EDGE_W-1:0] a_v_next [3];

    always_comb begin
        logic signed [EDGE_W-1:0] p0 [3];
        logic signed [EDGE_W-1:0] p1 [3];
        logic signed [EDGE_W-1:0] p2 [3];
        p0[0] = EDGE_W'(s_base_x);
        p0[1] = EDGE_W'(s_base_y);
        p0[2] = EDGE_W'(s_base_z);
        p1[0] = EDGE_W'(s_second_x);
        p1[1] = EDGE_W'(s_second_y);
        p1[2] = EDGE_W'(s_second_z);
        p2[0] = EDGE_W'(s_third_x);
        p2[1] = EDGE_W'(s_third_y);
        p2[2] = EDGE_W'(s_third_z);
        for (int i = 0; i < 3; i++) begin
            // point-normal mode keeps the normal in u
            a_u_next[i] = s_req_type ? p1[i] : p1[i] - p0[i];
            a_v_next[i] = p2[i] - p0[i];
        end
        a_side_next     = '0;
        a_side_next.pn  = s_req_type;
        a_side_next.up  = s_force_up;
        a_side_next.x   = s_base_x;
        a_side_next.y   = s_base_y;
        a_side_next.z   = s_base_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            a_u_reg    <= a_u_next;
            a_v_reg    <= a_v_next;
        end
    end

    // ---------------- B: cross product terms ----------------
    logic                     b_valid_reg;
    side_t                    b_side_reg;
    logic signed [EDGE_W-1:0] b_u_reg [3];
    logic signed [PROD_W-1:0] b_pr_reg [6];
    logic signed [PROD_W-1:0] b_pr_next [6];

    always_comb begin
        b_pr_next[0] = a_u_reg[1] * a_v_reg[2];
        b_pr_next[1] = a_u_reg[2] * a_v_reg[1];
        b_pr_next[2] = a_u_reg[2] * a_v_reg[0];
        b_pr_next[3] = a_u_reg[0] * a_v_reg[2];
        b_pr_next[4] = a_u_reg[0] * a_v_reg[1];
        b_pr_next[5] = a_u_reg[1] * a_v_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= a_side_reg;
            b_u_reg    <= a_u_reg;
            b_pr_reg   <= b_pr_next;
        end
    end

    // ---------------- C: raw normal ----------------
    logic                    c_valid_reg;
    side_t                   c_side_reg;
    logic signed [RAW_W-1:0] c_raw_reg [3];
    logic signed [RAW_W-1:0] c_raw_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_raw_next[i] = b_side_reg.pn ? RAW_W'(b_u_reg[i])
                                          : RAW_W'(b_pr_reg[2*i]) - RAW_W'(b_pr_reg[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= b_side_reg;
            c_raw_reg  <= c_raw_next;
        end
    end

    // ---------------- D: magnitude and sign ----------------
    logic             d_valid_reg;
    side_t            d_side_reg, d_side_next;
    logic [MAG_W-1:0] d_mag_reg [3];
    logic [MAG_W-1:0] d_mag_next [3];

    always_comb begin
        d_side_next = c_side_reg;
        for (int i = 0; i < 3; i++) begin
            d_side_next.neg[i] = c_raw_reg[i][RAW_W-1];
            d_mag_next[i] = MAG_W'(c_raw_reg[i][RAW_W-1] ? -c_raw_reg[i] : c_raw_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_side_reg <= d_side_next;
            d_mag_reg  <= d_mag_next;
        end
    end

    // ---------------- E: leading one, partial squares ----------------
    logic                e_valid_reg;
    side_t               e_side_reg;
    logic [MAG_W-1:0]    e_mag_reg [3];
    logic [BITS_W-1:0]   e_bits_reg, e_bits_next;
    logic [2*HALF_W-1:0] e_hh_reg [3];
    logic [2*HALF_W-1:0] e_hl_reg [3];
    logic [2*HALF_W-1:0] e_ll_reg [3];
    logic [2*HALF_W-1:0] e_hh_next [3];
    logic [2*HALF_W-1:0] e_hl_next [3];
    logic [2*HALF_W-1:0] e_ll_next [3];

    always_comb begin
        logic [MAG_W-1:0] any;
        any = d_mag_reg[0] | d_mag_reg[1] | d_mag_reg[2];
        e_bits_next = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (any[k]) begin
                e_bits_next = BITS_W'(k + 1);
            end
        end
        // exact square of the low 48 bits, split in 24-bit halves
        for (int i = 0; i < 3; i++) begin
            e_hh_next[i] = (2*HALF_W)'(d_mag_reg[i][2*HALF_W-1:HALF_W])
                         * (2*HALF_W)'(d_mag_reg[i][2*HALF_W-1:HALF_W]);
            e_hl_next[i] = (2*HALF_W)'(d_mag_reg[i][2*HALF_W-1:HALF_W])
                         * (2*HALF_W)'(d_mag_reg[i][HALF_W-1:0]);
            e_ll_next[i] = (2*HALF_W)'(d_mag_reg[i][HALF_W-1:0])
                         * (2*HALF_W)'(d_mag_reg[i][HALF_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg <= d_side_reg;
            e_mag_reg  <= d_mag_reg;
            e_bits_reg <= e_bits_next;
            e_hh_reg   <= e_hh_next;
            e_hl_reg   <= e_hl_next;
            e_ll_reg   <= e_ll_next;
        end
    end

    // ---------------- F: normalizing shift, squares ----------------
    logic              f_valid_reg;
    side_t             f_side_reg;
    logic [BITS_W-1:0] f_bits_reg;
    logic [NORM_W-1:0] f_m_reg [3];
    logic [NORM_W-1:0] f_m_next [3];
    logic [SQ_W-1:0]   f_sq_reg [3];
    logic [SQ_W-1:0]   f_sq_next [3];

    always_comb begin
        logic [MAG_W-1:0] shr;
        logic [NORM_W-1:0] shl;
        for (int i = 0; i < 3; i++) begin
            shr = e_mag_reg[i] >> (e_bits_reg - BITS_W'(NORM_W));
            shl = e_mag_reg[i][NORM_W-1:0] << (BITS_W'(NORM_W) - e_bits_reg);
            f_m_next[i] = (e_bits_reg > BITS_W'(NORM_W)) ? shr[NORM_W-1:0] : shl;
            f_sq_next[i] = (SQ_W'(e_hh_reg[i]) << (2*HALF_W))
                         + (SQ_W'(e_hl_reg[i]) << (HALF_W + 1))
                         + SQ_W'(e_ll_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg <= e_side_reg;
            f_bits_reg <= e_bits_reg;
            f_m_reg    <= f_m_next;
            f_sq_reg   <= f_sq_next;
        end
    end

    // ---------------- G: degenerate test, squares of normalized parts ----------------
    logic                g_valid_reg;
    side_t               g_side_reg, g_side_next;
    logic [NORM_W-1:0]   g_m_reg [3];
    logic [2*NORM_W-1:0] g_m2_reg [3];
    logic [2*NORM_W-1:0] g_m2_next [3];

    always_comb begin
        logic [LEN2_W-1:0] len2;
        logic [LEN2_W-1:0] lim;
        logic              big;
        len2 = LEN2_W'(f_sq_reg[0]) + LEN2_W'(f_sq_reg[1]) + LEN2_W'(f_sq_reg[2]);
        // three-point length is Q64.64, threshold is Q32.32
        lim  = f_side_reg.pn ? LEN2_W'(thr_reg) : LEN2_W'({thr_reg, 32'd0});
        big  = f_bits_reg > BIG_BITS;
        g_side_next     = f_side_reg;
        g_side_next.deg = (f_bits_reg == '0) || (!big && (len2 < lim));
        for (int i = 0; i < 3; i++) begin
            g_m2_next[i] = (2*NORM_W)'(f_m_reg[i]) * (2*NORM_W)'(f_m_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (en) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_side_reg <= g_side_next;
            g_m_reg    <= f_m_reg;
            g_m2_reg   <= g_m2_next;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic              sq_valid_reg [SQRT_STEPS+1];
    side_t             sq_side_reg  [SQRT_STEPS+1];
    logic [63:0]       sq_x_reg     [SQRT_STEPS+1];
    logic [63:0]       sq_res_reg   [SQRT_STEPS+1];
    logic [NORM_W-1:0] sq_m_reg     [SQRT_STEPS+1][3];
    logic [63:0]       sq_l_next;

    assign sq_l_next = 64'(g_m2_reg[0]) + 64'(g_m2_reg[1]) + 64'(g_m2_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= g_side_reg;
            sq_x_reg[0]    <= sq_l_next;
            sq_res_reg[0]  <= '0;
            sq_m_reg[0]    <= g_m_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2*k);
        logic [63:0] trial;
        logic [63:0] x_next;
        logic [63:0] res_next;

        assign trial    = sq_res_reg[k] + SQ_BIT;
        assign x_next   = (sq_x_reg[k] >= trial) ? sq_x_reg[k] - trial : sq_x_reg[k];
        assign res_next = (sq_x_reg[k] >= trial) ? (sq_res_reg[k] >> 1) + SQ_BIT
                                                 : (sq_res_reg[k] >> 1);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_x_reg[k+1]    <= x_next;
                sq_res_reg[k+1]  <= res_next;
                sq_m_reg[k+1]    <= sq_m_reg[k];
            end
        end
    end

    // ---------------- divider lanes, one quotient bit per stage ----------------
    logic              dv_valid_reg [DIV_STEPS+1];
    side_t             dv_side_reg  [DIV_STEPS+1];
    logic [ROOT_W-1:0] dv_root_reg  [DIV_STEPS+1];
    logic [ROOT_W-1:0] dv_rem_reg   [DIV_STEPS+1][3];
    logic [NORM_W-1:0] dv_lo_reg    [DIV_STEPS+1][3];
    logic [NORM_W-1:0] dv_q_reg     [DIV_STEPS+1][3];
    logic [ROOT_W-1:0] dv_root_next;
    logic [NUM_W-1:0]  dv_num_next  [3];

    always_comb begin
        dv_root_next = sq_res_reg[SQRT_STEPS][ROOT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            // m * 2^30 + R/2, rounds the quotient half up
            dv_num_next[i] = {sq_m_reg[SQRT_STEPS][i], 31'd0} >> 1;
            dv_num_next[i] = dv_num_next[i] + NUM_W'(dv_root_next[ROOT_W-1:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= sq_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= sq_side_reg[SQRT_STEPS];
            dv_root_reg[0] <= dv_root_next;
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= ROOT_W'(dv_num_next[i][NUM_W-1:NORM_W]);
                dv_lo_reg[0][i]  <= dv_num_next[i][NORM_W-1:0];
                dv_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
        localparam int QB = DIV_STEPS - 1 - s;
        logic [ROOT_W:0]   rem_sh   [3];
        logic              ge       [3];
        logic [ROOT_W-1:0] rem_next [3];
        logic [NORM_W-1:0] q_next   [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_sh[i]   = {dv_rem_reg[s][i], dv_lo_reg[s][i][QB]};
                ge[i]       = rem_sh[i] >= {1'b0, dv_root_reg[s]};
                rem_next[i] = ge[i] ? ROOT_W'(rem_sh[i] - {1'b0, dv_root_reg[s]})
                                    : rem_sh[i][ROOT_W-1:0];
                q_next[i]   = dv_q_reg[s][i];
                q_next[i][QB] = ge[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[s+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[s+1] <= dv_valid_reg[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[s+1] <= dv_side_reg[s];
                dv_root_reg[s+1] <= dv_root_reg[s];
                dv_rem_reg[s+1]  <= rem_next;
                dv_lo_reg[s+1]   <= dv_lo_reg[s];
                dv_q_reg[s+1]    <= q_next;
            end
        end
    end

    // ---------------- J: clamp, sign, flip ----------------
    logic                      j_valid_reg;
    side_t                     j_side_reg;
    logic signed [COORD_W-1:0] j_coef_reg [3];
    logic signed [COORD_W-1:0] j_coef_next [3];

    always_comb begin
        logic [NORM_W-1:0]         c;
        logic signed [COORD_W-1:0] pre [3];
        logic                      flip;
        for (int i = 0; i < 3; i++) begin
            c = (dv_q_reg[DIV_STEPS][i] > ONE_Q30) ? ONE_Q30 : dv_q_reg[DIV_STEPS][i];
            pre[i] = dv_side_reg[DIV_STEPS].neg[i] ? -$signed(COORD_W'(c))
                                                   : $signed(COORD_W'(c));
        end
        flip = !dv_side_reg[DIV_STEPS].pn && dv_side_reg[DIV_STEPS].up && pre[1][COORD_W-1];
        for (int i = 0; i < 3; i++) begin
            j_coef_next[i] = flip ? -pre[i] : pre[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_valid_reg <= 1'b0;
        end else if (en) begin
            j_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_side_reg <= dv_side_reg[DIV_STEPS];
            j_coef_reg <= j_coef_next;
        end
    end

    // ---------------- K: dot product terms ----------------
    logic                        k_valid_reg;
    side_t                       k_side_reg;
    logic signed [COORD_W-1:0]   k_coef_reg [3];
    logic signed [2*COORD_W-1:0] k_prod_reg [3];
    logic signed [2*COORD_W-1:0] k_prod_next [3];

    always_comb begin
        k_prod_next[0] = j_coef_reg[0] * j_side_reg.x;
        k_prod_next[1] = j_coef_reg[1] * j_side_reg.y;
        k_prod_next[2] = j_coef_reg[2] * j_side_reg.z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (en) begin
            k_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_side_reg <= j_side_reg;
            k_coef_reg <= j_coef_reg;
            k_prod_reg <= k_prod_next;
        end
    end

    // ---------------- L: dot product sum ----------------
    logic                      l_valid_reg;
    side_t                     l_side_reg;
    logic signed [COORD_W-1:0] l_coef_reg [3];
    logic signed [PROD_W-1:0]  l_sum_reg, l_sum_next;

    assign l_sum_next = PROD_W'(k_prod_reg[0]) + PROD_W'(k_prod_reg[1])
                      + PROD_W'(k_prod_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_valid_reg <= 1'b0;
        end else if (en) begin
            l_valid_reg <= k_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_side_reg <= k_side_reg;
            l_coef_reg <= k_coef_reg;
            l_sum_reg  <= l_sum_next;
        end
    end

    // ---------------- M: round, saturate, output register ----------------
    logic                      m_valid_reg;
    logic                      m_ok_reg, m_ok_next;
    logic signed [COORD_W-1:0] m_a_reg, m_b_reg, m_c_reg, m_d_reg;
    logic signed [COORD_W-1:0] m_a_next, m_b_next, m_c_next, m_d_next;

    always_comb begin
        logic [PROD_W-1:0]     absv;
        logic [PROD_W-30-1:0]  q;
        logic                  tneg;
        logic signed [COORD_W-1:0] d;
        // d = -sum, so d is negative when the sum is positive
        tneg = !l_sum_reg[PROD_W-1] && (l_sum_reg != '0);
        absv = l_sum_reg[PROD_W-1] ? PROD_W'(-l_sum_reg) : PROD_W'(l_sum_reg);
        q    = (PROD_W-30)'((absv + (PROD_W'(1) << 29)) >> 30);
        if (tneg) begin
            d = (q > 36'h0_8000_0000) ? 32'sh8000_0000 : -$signed(COORD_W'(q));
        end else begin
            d = (q > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(COORD_W'(q));
        end
        m_ok_next = !l_side_reg.deg;
        m_a_next  = l_side_reg.deg ? '0 : l_coef_reg[0];
        m_b_next  = l_side_reg.deg ? '0 : l_coef_reg[1];
        m_c_next  = l_side_reg.deg ? '0 : l_coef_reg[2];
        m_d_next  = l_side_reg.deg ? '0 : d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_ok_reg <= m_ok_next;
            m_a_reg  <= m_a_next;
            m_b_reg  <= m_b_next;
            m_c_reg  <= m_c_next;
            m_d_reg  <= m_d_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_plane_ok = m_ok_reg;
    assign m_coef_a   = m_a_reg;
    assign m_coef_b   = m_b_reg;
    assign m_coef_c   = m_c_reg;
    assign m_coef_d   = m_d_reg;

    // ---------------- checks ----------------
    `PES_ASSERT_IMPL(a_deg_zero, aclk, aresetn, m_valid && !m_plane_ok, (m_coef_a == '0) && (m_coef_b == '0) && (m_coef_c == '0) && (m_coef_d == '0))
    `PES_ASSERT_IMPL(a_unit_range, aclk, aresetn, m_valid, (m_coef_a <= 32'sd1073741824) && (m_coef_a >= -32'sd1073741824) && (m_coef_b <= 32'sd1073741824) && (m_coef_b >= -32'sd1073741824))
    `PES_ASSERT_IMPL(a_flip_up, aclk, aresetn, j_valid_reg && !j_side_reg.pn && j_side_reg.up, !j_coef_reg[1][COORD_W-1])

endmodule
`default_nettype wire

### dv/plane_equation_setup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane equation setup core testbench
// Streams three-point and point-normal items through the core under random
// source gaps and sink stalls, over several degenerate-threshold settings.
// Planes are checked against a bit-exact fixed-point builder or typed rows.
// ----------------------------------------------------------------------------
module plane_equation_setup_core_tb;
    import pes_pkg::*;

    localparam int  CLK_HALF    = 10;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  DRAIN_WAIT  = 120;
    localparam int  PHASE_ITEMS = 260;
    localparam bit  REQ_POINTS  = 1'b0;
    localparam bit  REQ_NORMAL  = 1'b1;
    localparam logic [31:0] Q30_POS = 32'h4000_0000;
    localparam logic [31:0] Q30_NEG = 32'hC000_0000;
    localparam logic [31:0] D_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] D_MIN   = 32'h8000_0000;
    localparam logic [31:0] Q16_ONE = 32'h0001_0000;

    typedef struct packed {
        logic            req;
        logic            up;
        logic [8:0][31:0] c;   // base xyz, second xyz, third xyz
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } plane_t;

    typedef struct packed {
        item_t  it;
        logic   typed;
        plane_t want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [THR_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_req_type = 1'b0;
    logic                s_force_up = 1'b0;
    logic signed [31:0]  s_base_x = '0, s_base_y = '0, s_base_z = '0;
    logic signed [31:0]  s_second_x = '0, s_second_y = '0, s_second_z = '0;
    logic signed [31:0]  s_third_x = '0, s_third_y = '0, s_third_z = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_plane_ok;
    logic signed [31:0]  m_coef_a, m_coef_b, m_coef_c, m_coef_d;

    plane_equation_setup_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_force_up(s_force_up),
        .s_base_x(s_base_x), .s_base_y(s_base_y), .s_base_z(s_base_z),
        .s_second_x(s_second_x), .s_second_y(s_second_y), .s_second_z(s_second_z),
        .s_third_x(s_third_x), .s_third_y(s_third_y), .s_third_z(s_third_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_plane_ok(m_plane_ok),
        .m_coef_a(m_coef_a), .m_coef_b(m_coef_b), .m_coef_c(m_coef_c),
        .m_coef_d(m_coef_d)
    );

    always #CLK_HALF aclk = ~aclk;

    logic [THR_W-1:0] thresh = THRESH_RESET;
    plane_t           planes_due[$];
    int               errors = 0;
    int               n_planes = 0;
    int               n_flat = 0;
    int               n_sent = 0;
    int               cycles = 0;
    bit               no_idle = 1'b0;

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > x) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (x >= res + bit_w) begin
                x = x - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic plane_t plane_of(input item_t it, input logic [THR_W-1:0] thr);
        logic signed [127:0] p0[3], p1[3], p2[3], u[3], v[3], raw[3], sum, t;
        logic [127:0] mag[3], len2, lim, at, q;
        logic         neg[3];
        logic         big;
        logic [63:0]  m[3], lsum, root, cq;
        logic signed [63:0] coef[3];
        int           bits, i, k;
        plane_t       r;
        r = '0;
        for (i = 0; i < 3; i++) begin
            p0[i] = $signed(it.c[i]);
            p1[i] = $signed(it.c[3+i]);
            p2[i] = $signed(it.c[6+i]);
            u[i] = p1[i] - p0[i];
            v[i] = p2[i] - p0[i];
        end
        if (it.req == REQ_NORMAL) begin
            for (i = 0; i < 3; i++) raw[i] = p1[i];
        end else begin
            raw[0] = u[1] * v[2] - u[2] * v[1];
            raw[1] = u[2] * v[0] - u[0] * v[2];
            raw[2] = u[0] * v[1] - u[1] * v[0];
        end
        bits = 0;
        big = 1'b0;
        len2 = 0;
        for (i = 0; i < 3; i++) begin
            neg[i] = raw[i] < 0;
            mag[i] = neg[i] ? -raw[i] : raw[i];
            for (k = 0; k < 128; k++) if (mag[i][k] && k + 1 > bits) bits = k + 1;
            if (mag[i] >= (128'd1 << 48)) big = 1'b1;
            else len2 = len2 + mag[i] * mag[i];
        end
        lim = (it.req == REQ_NORMAL) ? {65'd0, thr} : ({65'd0, thr} << 32);
        if (bits == 0 || (!big && len2 < lim)) return r;
        for (i = 0; i < 3; i++)
            m[i] = (bits > 31) ? 64'(mag[i] >> (bits - 31)) : 64'(mag[i] << (31 - bits));
        lsum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        root = root_floor(lsum);
        for (i = 0; i < 3; i++) begin
            cq = (m[i] * 64'd1073741824 + (root >> 1)) / root;
            if (cq > 64'd1073741824) cq = 64'd1073741824;
            coef[i] = neg[i] ? -$signed(cq) : $signed(cq);
        end
        if (it.req == REQ_POINTS && it.up && coef[1] < 0)
            for (i = 0; i < 3; i++) coef[i] = -coef[i];
        sum = 0;
        for (i = 0; i < 3; i++) sum = sum + 128'(coef[i]) * p0[i];
        t = -sum;
        at = (t < 0) ? -t : t;
        q = (at + (128'd1 << 29)) >> 30;
        if (t < 0) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            r.d = -q[31:0];
        end else begin
            if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
            r.d = q[31:0];
        end
        r.ok = 1'b1;
        r.a = coef[0][31:0];
        r.b = coef[1][31:0];
        r.c = coef[2][31:0];
        return r;
    endfunction

    // mostly zero, a few long
    function automatic int idle_len();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [31:0] rand_coord(input int sh);
        return 32'($signed($urandom) >>> sh);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    kind, sh, i, f;
        logic signed [31:0] dl;
        kind = $urandom_range(0, 9);
        sh = $urandom_range(0, 31);
        it.req = REQ_POINTS;
        it.up = $urandom_range(0, 1);
        for (i = 0; i < 9; i++) it.c[i] = rand_coord(sh);
        if (kind >= 6 && kind <= 8) begin
            it.req = REQ_NORMAL;
        end else if (kind == 9) begin
            // collinear or coincident points
            f = $urandom_range(0, 3);
            for (i = 0; i < 3; i++) begin
                dl = $signed(rand_coord(sh)) >>> 4;
                it.c[3+i] = it.c[i] + dl;
                it.c[6+i] = it.c[i] + f * dl;
            end
        end
        return it;
    endfunction

    task automatic send_item(input item_t it, input plane_t want);
        int  g;
        bit  rdy;
        g = idle_len();
        repeat (g) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= it.req;
        s_force_up <= it.up;
        s_base_x   <= it.c[0];
        s_base_y   <= it.c[1];
        s_base_z   <= it.c[2];
        s_second_x <= it.c[3];
        s_second_y <= it.c[4];
        s_second_z <= it.c[5];
        s_third_x  <= it.c[6];
        s_third_y  <= it.c[7];
        s_third_z  <= it.c[8];
        do begin
            @(negedge aclk);
            rdy = s_ready;
            if (rdy) planes_due.push_back(want);
            @(posedge aclk);
        end while (!rdy);
        n_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (planes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_thresh(input logic [THR_W-1:0] val);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        thresh = val;
    endtask

    // result sink: random stalls, none while no_idle is set
    int stall = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (no_idle) begin
            m_ready <= 1'b1;
        end else if (stall > 0) begin
            stall <= stall - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall <= idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(negedge aclk) begin
        plane_t want;
        if (aresetn && m_valid && m_ready) begin
            if (planes_due.size() == 0) begin
                $display("%0t: unexpected plane ok=%0b a=%h b=%h c=%h d=%h", $time,
                         m_plane_ok, m_coef_a, m_coef_b, m_coef_c, m_coef_d);
                errors++;
            end else begin
                want = planes_due.pop_front();
                n_planes++;
                if (!want.ok) n_flat++;
                if (m_plane_ok !== want.ok) begin
                    $display("%0t: plane_ok exp %0b got %0b", $time, want.ok, m_plane_ok);
                    errors++;
                end
                if (m_coef_a !== want.a) begin
                    $display("%0t: coef_a exp %h got %h", $time, want.a, m_coef_a);
                    errors++;
                end
                if (m_coef_b !== want.b) begin
                    $display("%0t: coef_b exp %h got %h", $time, want.b, m_coef_b);
                    errors++;
                end
                if (m_coef_c !== want.c) begin
                    $display("%0t: coef_c exp %h got %h", $time, want.c, m_coef_c);
                    errors++;
                end
                if (m_coef_d !== want.d) begin
                    $display("%0t: coef_d exp %h got %h", $time, want.d, m_coef_d);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d planes pending", cycles, planes_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    row_t rows[15];

    initial begin
        item_t it;
        int    i, ph;
        logic [THR_W-1:0] th;
        for (i = 0; i < 15; i++) begin
            rows[i] = '0;
            rows[i].it.req = REQ_NORMAL;
        end
        // zero normal: always degenerate
        rows[0].typed = 1'b1;
        // coincident points
        rows[1].it.req = REQ_POINTS;
        for (i = 0; i < 9; i++) rows[1].it.c[i] = 32'h0012_3456;
        rows[1].typed = 1'b1;
        rows[2].it.c[3] = Q16_ONE;
        rows[2].typed = 1'b1;
        rows[2].want = '{1'b1, Q30_POS, 32'd0, 32'd0, 32'd0};
        // force up is ignored for a given normal
        rows[3].it.up = 1'b1;
        rows[3].it.c[4] = -Q16_ONE;
        rows[3].typed = 1'b1;
        rows[3].want = '{1'b1, 32'd0, Q30_NEG, 32'd0, 32'd0};
        // d saturates high and low
        rows[4].it.c[3] = Q16_ONE;
        rows[4].it.c[0] = D_MIN;
        rows[4].typed = 1'b1;
        rows[4].want = '{1'b1, Q30_POS, 32'd0, 32'd0, D_MAX};
        rows[5].it.c[3] = -Q16_ONE;
        rows[5].it.c[0] = D_MIN;
        rows[5].typed = 1'b1;
        rows[5].want = '{1'b1, Q30_NEG, 32'd0, 32'd0, D_MIN};
        // normal with negative y, without and with flip
        rows[6].it.req = REQ_POINTS;
        rows[6].it.c[3] = Q16_ONE;
        rows[6].it.c[8] = Q16_ONE;
        rows[6].it.c[1] = 32'h0003_0000;
        rows[6].it.c[4] = 32'h0003_0000;
        rows[6].it.c[7] = 32'h0003_0000;
        rows[7] = rows[6];
        rows[7].it.up = 1'b1;
        for (i = 0; i < 9; i++) begin
            rows[8].it.c[i]  = D_MAX;
            rows[9].it.c[i]  = D_MIN;
            rows[10].it.c[i] = D_MAX;
            rows[11].it.c[i] = D_MIN;
            rows[12].it.c[i] = D_MIN;
        end
        rows[8].it.req = REQ_POINTS;
        rows[9].it.req = REQ_POINTS;
        rows[10].it.up = 1'b1;
        rows[12].it.req = REQ_POINTS;
        rows[12].it.up = 1'b1;
        rows[12].it.c[3] = D_MAX;
        rows[12].it.c[7] = D_MAX;
        // tiny normals below the reset threshold
        rows[13].it.req = REQ_POINTS;
        rows[13].it.c[3] = 32'd1;
        rows[13].it.c[7] = 32'd1;
        rows[14].it.c[3] = 32'd1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 15; i++)
            send_item(rows[i].it, rows[i].typed ? rows[i].want : plane_of(rows[i].it, thresh));

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                1: th = '0;
                2: th = {THR_W{1'b1}};
                3: th = 63'($urandom_range(0, 31)) << $urandom_range(0, 62);
                4: th = THRESH_RESET;
                default: th = thresh;
            endcase
            if (ph != 0) set_thresh(th);
            no_idle = (ph == 3);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 1 && i == 100) drain();
                it = rand_item();
                send_item(it, plane_of(it, thresh));
            end
            no_idle = 1'b0;
        end
        // random wide threshold at the end
        set_thresh(THR_W'({$urandom, $urandom}));
        for (i = 0; i < 40; i++) begin
            it = rand_item();
            send_item(it, plane_of(it, thresh));
        end
        drain();

        $display("sent %0d items, checked %0d planes (%0d degenerate) over 6 thresholds",
                 n_sent, n_planes, n_flat);
        if (errors == 0 && planes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### files.f
+incdir+design
design/pes_pkg.sv
design/plane_equation_setup_core.sv
dv/plane_equation_setup_core_tb.sv
